// ===== hw/rtl/uptf_pkg.sv =====
// Shared types and character constants for the URI path traversal filter.
`default_nettype none

package uptf_pkg;

  // Position of the scanner relative to path start and slashes
  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_START_DOT  = 3'd1,
    PH_START_DOT2 = 3'd2,
    PH_SLASH      = 3'd3,
    PH_SLASH_DOT  = 3'd4,
    PH_PLAIN      = 3'd5
  } scan_phase_e;

  // Progress through a percent escape
  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_PERCENT = 2'd1,
    ESC_DIGIT   = 2'd2
  } esc_progress_e;

  // Bytes the scanner looks for
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChTwo     = 8'h32;
  localparam logic [7:0] ChLowE    = 8'h65;
  localparam logic [7:0] ChUpE     = 8'h45;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChSlash   = 8'h2f;

  // Scanner state carried from byte to byte
  typedef struct packed {
    scan_phase_e   phase;
    esc_progress_e esc;
    logic          esc_is_two;  // second escape char was '2' (else '0')
    logic          esc_dot_ctx; // pending '%' stands where an encoded dot is banned
    logic          rejected;
    logic          ended;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    phase:       PH_START,
    esc:         ESC_NONE,
    esc_is_two:  1'b0,
    esc_dot_ctx: 1'b0,
    rejected:    1'b0,
    ended:       1'b0
  };

  // Phases in which the string must not end
  function automatic logic dot_phase(input scan_phase_e ph);
    return (ph == PH_START_DOT) || (ph == PH_START_DOT2) || (ph == PH_SLASH_DOT);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uptf_scan.sv =====
// Byte scanner: state register and per-byte next-state and verdict logic.
`default_nettype none

module uptf_scan
  import uptf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,   // consume one byte this cycle
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            ok_o      // verdict, meaningful when last_i is set
);

  scan_state_t state_q, state_d;
  scan_state_t work;
  logic        is_e, is_f, rej_fin;

  assign is_e = (byte_i == ChLowE) || (byte_i == ChUpE);
  assign is_f = (byte_i == ChLowF) || (byte_i == ChUpF);

  // Compute next state and the verdict for the current byte
  always_comb begin
    work = state_q;
    if (!state_q.ended) begin
      if (byte_i == ChNul) begin
        if (dot_phase(state_q.phase)) work.rejected = 1'b1;
        work.ended = 1'b1;
        work.esc   = ESC_NONE;
      end else begin
        // escape matching
        case (state_q.esc)
          ESC_DIGIT: begin
            if (!state_q.esc_is_two) begin
              if (byte_i == ChZero) work.rejected = 1'b1;
            end else begin
              if (is_f) work.rejected = 1'b1;
              if (is_e && state_q.esc_dot_ctx) work.rejected = 1'b1;
            end
            work.esc = ESC_NONE;
          end
          ESC_PERCENT: begin
            if (byte_i == ChZero) begin
              work.esc        = ESC_DIGIT;
              work.esc_is_two = 1'b0;
            end else if (byte_i == ChTwo) begin
              work.esc        = ESC_DIGIT;
              work.esc_is_two = 1'b1;
            end else begin
              work.esc = ESC_NONE;
            end
          end
          default: ;
        endcase
        if (byte_i == ChPercent) begin
          work.esc         = ESC_PERCENT;
          work.esc_dot_ctx = (state_q.phase == PH_START) || (state_q.phase == PH_START_DOT) ||
                             (state_q.phase == PH_SLASH) || (state_q.phase == PH_SLASH_DOT);
        end
        // phase tracking
        case (state_q.phase)
          PH_START: begin
            work.phase = (byte_i == ChDot) ? PH_START_DOT :
                         (byte_i == ChSlash) ? PH_SLASH : PH_PLAIN;
          end
          PH_START_DOT: begin
            if (byte_i == ChSlash) work.rejected = 1'b1;
            work.phase = (byte_i == ChDot) ? PH_START_DOT2 :
                         (byte_i == ChSlash) ? PH_SLASH : PH_PLAIN;
          end
          PH_START_DOT2: begin
            if (byte_i == ChSlash) work.rejected = 1'b1;
            work.phase = (byte_i == ChSlash) ? PH_SLASH : PH_PLAIN;
          end
          PH_SLASH: begin
            work.phase = (byte_i == ChDot) ? PH_SLASH_DOT :
                         (byte_i == ChSlash) ? PH_SLASH : PH_PLAIN;
          end
          PH_SLASH_DOT: begin
            if ((byte_i == ChSlash) || (byte_i == ChDot)) work.rejected = 1'b1;
            work.phase = (byte_i == ChSlash) ? PH_SLASH : PH_PLAIN;
          end
          default: begin
            work.phase = (byte_i == ChSlash) ? PH_SLASH : PH_PLAIN;
          end
        endcase
      end
    end
    // close the string on the last byte if no NUL did so
    rej_fin = work.rejected || (!work.ended && dot_phase(work.phase));
    ok_o    = !rej_fin;
    state_d = last_i ? ScanReset : work;
  end

  // Advance the scanner state on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ScanReset;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uri_path_traversal_filter_unit.sv =====
// Top level: input register, byte scanner and verdict output register.
// A verdict is registered on the master side when the scanner consumes its last byte.
// Throughput: one byte per cycle; the input register is freed as the scanner consumes it.
// A last byte waits in the input register only while an earlier verdict is not taken.
// Reset (rst_ni low, asynchronous): all valid flags and scanner state clear; next byte
// starts a new path.
`default_nettype none

module uri_path_traversal_filter_unit
  import uptf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] path_byte
  input  wire logic       s_axis_tlast_i,   // last_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] path_ok, [7:1] zero
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       out_ok_q;
  logic       out_free;
  logic       step;
  logic       scan_ok;

  // Consume the held request unless it needs a busy output slot
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || step;

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  uptf_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .ok_o   (scan_ok)
  );

  // Load the verdict on a last byte, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_ok_q <= scan_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_ok_q};

endmodule

`default_nettype wire

// ===== bench/uri_path_traversal_filter_unit_tb.sv =====
// Testbench for the URI path traversal filter: directed and random paths, verdicts checked.
`default_nettype none

module uri_path_traversal_filter_unit_tb;
  import uptf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] path_byte
  logic       s_axis_tlast_i = 1'b0;    // last_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [0] path_ok, [7:1] zero

  // Expected verdicts, oldest first
  bit          verdict_q[$];
  int          err_cnt = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_cnt = 0;
  int          quiet_cycles = 0;

  // Scanner state of the prediction
  scan_phase_e   path_phase = PH_START;
  esc_progress_e esc_state = ESC_NONE;
  logic          esc_after_two = 1'b0;
  logic          esc_dot_banned = 1'b0;
  logic          path_rejected = 1'b0;
  logic          path_ended = 1'b0;

  uri_path_traversal_filter_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Return the scan to the start of a new path
  function automatic void clear_scan();
    path_phase     = PH_START;
    esc_state      = ESC_NONE;
    esc_after_two  = 1'b0;
    esc_dot_banned = 1'b0;
    path_rejected  = 1'b0;
    path_ended     = 1'b0;
  endfunction

  // Close the string; a dangling dot at the end rejects
  function automatic void close_path();
    if (path_phase inside {PH_START_DOT, PH_START_DOT2, PH_SLASH_DOT}) path_rejected = 1'b1;
    path_ended = 1'b1;
    esc_state  = ESC_NONE;
  endfunction

  // Advance escape matching and the slash/dot phase by one byte
  function automatic void scan_path_char(input logic [7:0] c);
    scan_phase_e ph;
    ph = path_phase;
    if (esc_state == ESC_DIGIT) begin
      if (!esc_after_two) begin
        if (c == ChZero) path_rejected = 1'b1;
      end else begin
        if (c == ChLowF || c == ChUpF) path_rejected = 1'b1;
        if ((c == ChLowE || c == ChUpE) && esc_dot_banned) path_rejected = 1'b1;
      end
      esc_state = ESC_NONE;
    end else if (esc_state == ESC_PERCENT) begin
      if (c == ChZero) begin
        esc_state     = ESC_DIGIT;
        esc_after_two = 1'b0;
      end else if (c == ChTwo) begin
        esc_state     = ESC_DIGIT;
        esc_after_two = 1'b1;
      end else begin
        esc_state = ESC_NONE;
      end
    end
    // A percent always opens a fresh escape
    if (c == ChPercent) begin
      esc_state      = ESC_PERCENT;
      esc_dot_banned = ph inside {PH_START, PH_START_DOT, PH_SLASH, PH_SLASH_DOT};
    end
    case (ph)
      PH_START: begin
        path_phase = (c == ChDot) ? PH_START_DOT : (c == ChSlash) ? PH_SLASH : PH_PLAIN;
      end
      PH_START_DOT: begin
        if (c == ChSlash) path_rejected = 1'b1;
        path_phase = (c == ChDot) ? PH_START_DOT2 : (c == ChSlash) ? PH_SLASH : PH_PLAIN;
      end
      PH_START_DOT2: begin
        if (c == ChSlash) path_rejected = 1'b1;
        path_phase = (c == ChSlash) ? PH_SLASH : PH_PLAIN;
      end
      PH_SLASH: begin
        path_phase = (c == ChDot) ? PH_SLASH_DOT : (c == ChSlash) ? PH_SLASH : PH_PLAIN;
      end
      PH_SLASH_DOT: begin
        if (c == ChSlash || c == ChDot) path_rejected = 1'b1;
        path_phase = (c == ChSlash) ? PH_SLASH : PH_PLAIN;
      end
      default: begin
        path_phase = (c == ChSlash) ? PH_SLASH : PH_PLAIN;
      end
    endcase
  endfunction

  // Fold one accepted request into the prediction; queue a verdict on last
  function automatic void predict_path_byte(input logic [7:0] c, input logic last);
    if (!path_ended) begin
      if (c == ChNul) close_path();
      else scan_path_char(c);
    end
    if (last) begin
      if (!path_ended) close_path();
      verdict_q.push_back(!path_rejected);
      clear_scan();
    end
  endfunction

  // Offer one byte, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_path_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_path_byte(c, last);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_path_byte(s[i], i == s.len() - 1);
  endtask

  // Bias toward the bytes the scanner reacts to
  function automatic logic [7:0] pick_path_byte();
    case ($urandom_range(15))
      0, 1:    return ChDot;
      2, 3:    return ChSlash;
      4, 11:   return ChPercent;
      5:       return ChZero;
      6:       return ChTwo;
      7:       return ChLowE;
      8:       return ChUpE;
      9:       return ChLowF;
      10:      return ChUpF;
      12:      return ($urandom_range(3) == 0) ? ChNul : 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send one path of random length and content; return its byte count
  task automatic send_random_path(output int len);
    bit lead_slash;
    len = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    lead_slash = 1'($urandom_range(1));
    for (int i = 0; i < len; i++)
      send_path_byte((i == 0 && lead_slash) ? ChSlash : pick_path_byte(), i == len - 1);
  endtask

  // Drop valid and wait until every verdict is back
  task automatic drain_verdicts();
    s_axis_tvalid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_paths();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_path_byte(ChNul, 1'b1);      // empty string
    send_path_byte(8'hFF, 1'b1);      // lone nonzero last byte
    send_string(".");
    send_string("../");
    send_string("/..");
    send_string("%00");
    send_string("%2E");
    send_string("%2");                // escape cut short
    send_string("%%2f");              // overlapping escapes
    send_path_byte(8'h61, 1'b0);      // bytes after NUL are ignored
    send_path_byte(ChNul, 1'b0);
    send_string("%2f");
    drain_verdicts();
  endtask

  task automatic test_random_paths(input int tx_pct, input int rx_pct, input int n_bytes);
    int sent;
    int len;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_bytes) begin
      send_random_path(len);
      sent += len;
    end
    drain_verdicts();
  endtask

  // Hold the output off for a long stretch while paths keep coming
  task automatic test_output_holdoff();
    int sent;
    int len;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_cnt  = 300;
    sent = 0;
    while (sent < 80) begin
      send_random_path(len);
      sent += len;
    end
    drain_verdicts();
  endtask

  // Drive the output ready: long hold-off first, then random stalls
  always @(posedge clk_i) begin
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each verdict with the oldest expectation
  always @(posedge clk_i) begin : verdict_check
    bit exp_ok;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: path_ok actual %0b", m_axis_tdata_o[0]);
        err_cnt++;
      end else begin
        exp_ok = verdict_q[0];
        verdict_q.delete(0);
        if (m_axis_tdata_o[0] !== exp_ok) begin
          $error("path_ok mismatch: expected %0b actual %0b", exp_ok, m_axis_tdata_o[0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[7:1] !== 7'd0) begin
          $error("tdata pad mismatch: expected 0 actual %0h", m_axis_tdata_o[7:1]);
          err_cnt++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_paths();
    test_random_paths(0, 0, 160);
    test_random_paths(88, 0, 160);
    test_random_paths(0, 88, 160);
    test_random_paths(6, 6, 160);
    test_output_holdoff();
    // Leave room for a stray verdict to show up
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
